>>> design/flp_pkg.sv
// shared types and constants for the flow layout placer
package flp_pkg;

  // width of the item size fields
  localparam int ITEM_BITS = 15;

  // configuration register index width and codes
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_COLUMN_MODE = 3'd0,
    CFG_BOX_LEFT    = 3'd1,
    CFG_BOX_TOP     = 3'd2,
    CFG_BOX_RIGHT   = 3'd3,
    CFG_BOX_BOTTOM  = 3'd4,
    CFG_GAP_X       = 3'd5,
    CFG_GAP_Y       = 3'd6
  } cfg_idx_t;

  // one input rectangle as held in the input register
  typedef struct packed {
    logic                 final_item;
    logic [ITEM_BITS-1:0] item_height;
    logic [ITEM_BITS-1:0] item_width;
  } item_t;

endpackage

>>> design/flp_cfg.sv
// configuration register file of the flow layout placer
module flp_cfg #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [flp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data,
  output logic                                column_mode,
  output logic signed [COORD_BITS-1:0]        box_left,
  output logic signed [COORD_BITS-1:0]        box_top,
  output logic signed [COORD_BITS-1:0]        box_right,
  output logic signed [COORD_BITS-1:0]        box_bottom,
  output logic signed [COORD_BITS-1:0]        gap_x,
  output logic signed [COORD_BITS-1:0]        gap_y
);
  import flp_pkg::*;

  // writes are always accepted
  assign cfg_ready = 1'b1;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      column_mode <= 1'b0;
      box_left    <= '0;
      box_top     <= '0;
      box_right   <= '0;
      box_bottom  <= '0;
      gap_x       <= '0;
      gap_y       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COLUMN_MODE: column_mode <= cfg_data[0];
        CFG_BOX_LEFT:    box_left    <= cfg_data;
        CFG_BOX_TOP:     box_top     <= cfg_data;
        CFG_BOX_RIGHT:   box_right   <= cfg_data;
        CFG_BOX_BOTTOM:  box_bottom  <= cfg_data;
        CFG_GAP_X:       gap_x       <= cfg_data;
        CFG_GAP_Y:       gap_y       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> design/flp_place.sv
// placement logic and layout state: cursor, line extent and running bounds
module flp_place #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  flp_pkg::item_t                item,
  input  logic                          column_mode,
  input  logic signed [COORD_BITS-1:0]  box_left,
  input  logic signed [COORD_BITS-1:0]  box_top,
  input  logic signed [COORD_BITS-1:0]  box_right,
  input  logic signed [COORD_BITS-1:0]  box_bottom,
  input  logic signed [COORD_BITS-1:0]  gap_x,
  input  logic signed [COORD_BITS-1:0]  gap_y,
  output logic [COORD_BITS-1:0]         pos_x,
  output logic [COORD_BITS-1:0]         pos_y,
  output logic [COORD_BITS-1:0]         bound_left,
  output logic [COORD_BITS-1:0]         bound_top,
  output logic [COORD_BITS-1:0]         bound_right,
  output logic [COORD_BITS-1:0]         bound_bottom
);
  import flp_pkg::*;

  // inner coordinate width and a sum width that cannot overflow
  localparam int IB = COORD_BITS + 2;
  localparam int WB = ((IB > ITEM_BITS + 1) ? IB : ITEM_BITS + 1) + 2;

  localparam logic signed [WB-1:0] INNER_MAX =
    $signed({{(WB-IB+1){1'b0}}, {(IB-1){1'b1}}});
  localparam logic signed [WB-1:0] INNER_MIN = ~INNER_MAX;
  localparam logic signed [WB-1:0] OUT_MAX =
    $signed({{(WB-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [WB-1:0] OUT_MIN = ~OUT_MAX;

  function automatic logic signed [WB-1:0] ext_c(input logic signed [COORD_BITS-1:0] v);
    ext_c = $signed({{(WB-COORD_BITS){v[COORD_BITS-1]}}, v});
  endfunction

  function automatic logic signed [WB-1:0] ext_i(input logic signed [IB-1:0] v);
    ext_i = $signed({{(WB-IB){v[IB-1]}}, v});
  endfunction

  function automatic logic signed [WB-1:0] ext_u(input logic [ITEM_BITS-1:0] v);
    ext_u = $signed({{(WB-ITEM_BITS){1'b0}}, v});
  endfunction

  function automatic logic signed [IB-1:0] sat_inner(input logic signed [WB-1:0] v);
    logic signed [WB-1:0] c;
    c = (v > INNER_MAX) ? INNER_MAX : ((v < INNER_MIN) ? INNER_MIN : v);
    sat_inner = c[IB-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] sat_out(input logic signed [IB-1:0] v);
    logic signed [WB-1:0] e;
    logic signed [WB-1:0] c;
    e = ext_i(v);
    c = (e > OUT_MAX) ? OUT_MAX : ((e < OUT_MIN) ? OUT_MIN : e);
    sat_out = c[COORD_BITS-1:0];
  endfunction

  // layout state
  logic signed [IB-1:0]        cursor_x, cursor_y;
  logic [ITEM_BITS-1:0]        line_extent;
  logic signed [IB-1:0]        bnd_l, bnd_t, bnd_r, bnd_b;
  logic                        started;

  logic signed [IB-1:0]        cursor_x_next, cursor_y_next;
  logic [ITEM_BITS-1:0]        line_extent_next;
  logic signed [IB-1:0]        bnd_l_next, bnd_t_next, bnd_r_next, bnd_b_next;

  logic signed [WB-1:0]        base_x, base_y, bl_w, bt_w, w_w, h_w, ext_w, sx_w, sy_w;
  logic [ITEM_BITS-1:0]        ext0, ext1;
  logic                        wrap_row, wrap_col;
  logic signed [IB-1:0]        px, py, rgt, btm;

  // placement of the current item
  always_comb begin
    bl_w   = ext_c(box_left);
    bt_w   = ext_c(box_top);
    base_x = started ? ext_i(cursor_x) : bl_w;
    base_y = started ? ext_i(cursor_y) : bt_w;
    ext0   = started ? line_extent : '0;
    ext_w  = ext_u(ext0);
    w_w    = ext_u(item.item_width);
    h_w    = ext_u(item.item_height);
    sx_w   = gap_x[COORD_BITS-1] ? '0 : ext_c(gap_x);
    sy_w   = gap_y[COORD_BITS-1] ? '0 : ext_c(gap_y);

    wrap_row = !column_mode && (base_x > bl_w) && (base_x + w_w > ext_c(box_right));
    wrap_col = column_mode && (base_y > bt_w) && (base_y + h_w > ext_c(box_bottom));

    if (wrap_row) begin
      px = sat_inner(bl_w);
      py = sat_inner(base_y + ext_w + sy_w);
    end else if (wrap_col) begin
      px = sat_inner(base_x + ext_w + sx_w);
      py = sat_inner(bt_w);
    end else begin
      px = sat_inner(base_x);
      py = sat_inner(base_y);
    end
    ext1 = (wrap_row || wrap_col) ? '0 : ext0;

    rgt = sat_inner(ext_i(px) + w_w);
    btm = sat_inner(ext_i(py) + h_w);

    // running bounds, restarted at the first item of a layout
    if (!started) begin
      bnd_l_next = px;
      bnd_t_next = py;
      bnd_r_next = rgt;
      bnd_b_next = btm;
    end else begin
      bnd_l_next = (px < bnd_l) ? px : bnd_l;
      bnd_t_next = (py < bnd_t) ? py : bnd_t;
      bnd_r_next = (rgt > bnd_r) ? rgt : bnd_r;
      bnd_b_next = (btm > bnd_b) ? btm : bnd_b;
    end

    // advance the cursor along the line
    if (column_mode) begin
      line_extent_next = (item.item_width > ext1) ? item.item_width : ext1;
      cursor_x_next    = px;
      cursor_y_next    = sat_inner(ext_i(py) + h_w + sy_w);
    end else begin
      line_extent_next = (item.item_height > ext1) ? item.item_height : ext1;
      cursor_x_next    = sat_inner(ext_i(px) + w_w + sx_w);
      cursor_y_next    = py;
    end
  end

  // state update on each transfer through the placement stage
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x    <= '0;
      cursor_y    <= '0;
      line_extent <= '0;
      bnd_l       <= '0;
      bnd_t       <= '0;
      bnd_r       <= '0;
      bnd_b       <= '0;
      started     <= 1'b0;
    end else if (fire) begin
      cursor_x    <= cursor_x_next;
      cursor_y    <= cursor_y_next;
      line_extent <= line_extent_next;
      bnd_l       <= bnd_l_next;
      bnd_t       <= bnd_t_next;
      bnd_r       <= bnd_r_next;
      bnd_b       <= bnd_b_next;
      started     <= !item.final_item;
    end
  end

  // result fields, saturated to the port range
  assign pos_x        = sat_out(px);
  assign pos_y        = sat_out(py);
  assign bound_left   = sat_out(bnd_l_next);
  assign bound_top    = sat_out(bnd_t_next);
  assign bound_right  = sat_out(bnd_r_next);
  assign bound_bottom = sat_out(bnd_b_next);

endmodule

>>> design/flow_layout_placer.sv
// top level of the flow layout placer: input register, placement stage, result register
//
//   channel  direction  transfer when            payload
//   s_*      in         s_tvalid & s_tready      tdata: width, height; tlast: final item
//   m_*      out        m_tvalid & m_tready      tdata: pos and bounds; tlast: final
//   cfg_*    in         cfg_valid & cfg_ready    cfg_index, cfg_data
//
// one item per cycle unless m_tready stalls; input register feeds the result register
// the layout state lives in one register set updated in the placement stage
// reset (rst, synchronous) clears config, layout state and both valid flags
// a stall on m_tready holds the result register, then the input register
module flow_layout_placer #(
  parameter int COORD_BITS = 16
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            s_tvalid,
  output logic                                            s_tready,
  // item_width [14:0], item_height [29:15], zero pad
  input  logic [31:0]                                     s_tdata,
  // final_item
  input  logic                                            s_tlast,
  output logic                                            m_tvalid,
  input  logic                                            m_tready,
  // pos_x, pos_y, bound_left, bound_top, bound_right, bound_bottom, zero pad
  output logic [((6*COORD_BITS+7)/8)*8-1:0]               m_tdata,
  // final_out
  output logic                                            m_tlast,
  input  logic                                            cfg_valid,
  output logic                                            cfg_ready,
  input  logic [flp_pkg::CFG_IDX_BITS-1:0]                cfg_index,
  input  logic [COORD_BITS-1:0]                           cfg_data
);
  import flp_pkg::*;

  localparam int OUT_BITS = ((6*COORD_BITS+7)/8)*8;

  logic                         column_mode;
  logic signed [COORD_BITS-1:0] box_left, box_top, box_right, box_bottom, gap_x, gap_y;

  logic                         in_vld;
  item_t                        in_item;
  logic                         out_vld;
  logic [OUT_BITS-1:0]          out_data;
  logic                         out_last;
  logic                         fire;
  logic [COORD_BITS-1:0]        pos_x, pos_y, bound_left, bound_top, bound_right, bound_bottom;

  flp_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .column_mode (column_mode),
    .box_left    (box_left),
    .box_top     (box_top),
    .box_right   (box_right),
    .box_bottom  (box_bottom),
    .gap_x       (gap_x),
    .gap_y       (gap_y)
  );

  // the placement stage moves when the result register is free or draining
  assign fire     = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.item_width  <= s_tdata[ITEM_BITS-1:0];
      in_item.item_height <= s_tdata[2*ITEM_BITS-1:ITEM_BITS];
      in_item.final_item  <= s_tlast;
    end
  end

  flp_place #(.COORD_BITS(COORD_BITS)) u_place (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .item         (in_item),
    .column_mode  (column_mode),
    .box_left     (box_left),
    .box_top      (box_top),
    .box_right    (box_right),
    .box_bottom   (box_bottom),
    .gap_x        (gap_x),
    .gap_y        (gap_y),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .bound_left   (bound_left),
    .bound_top    (bound_top),
    .bound_right  (bound_right),
    .bound_bottom (bound_bottom)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (!out_vld || m_tready) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= OUT_BITS'({bound_bottom, bound_right, bound_top, bound_left,
                             pos_y, pos_x});
      out_last <= in_item.final_item;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

  // the placed corner lies inside the reported bounds
  a_bound_lt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[3*COORD_BITS-1:2*COORD_BITS]) <=
                  $signed(m_tdata[COORD_BITS-1:0])) &&
                 ($signed(m_tdata[4*COORD_BITS-1:3*COORD_BITS]) <=
                  $signed(m_tdata[2*COORD_BITS-1:COORD_BITS])))
    else $error("bounds do not cover the placed corner");

  a_bound_rb: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[5*COORD_BITS-1:4*COORD_BITS]) >=
                  $signed(m_tdata[COORD_BITS-1:0])) &&
                 ($signed(m_tdata[6*COORD_BITS-1:5*COORD_BITS]) >=
                  $signed(m_tdata[2*COORD_BITS-1:COORD_BITS])))
    else $error("far bounds lie before the placed corner");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !fire) |=> in_vld && $stable(in_item))
    else $error("input register lost an item while the stage was stalled");

endmodule
